@@ rtl/psp_pkg.sv @@
// shared types and constants of the pid servo pulse controller
package psp_pkg;

    localparam int GAIN_FRAC_BITS_DEF = 16;

    localparam int GAIN_W   = 32;
    localparam int PULSE_W  = 16;
    localparam int RPM_W    = 16;
    localparam int TIME_W   = 32;
    localparam int ERR_W    = RPM_W + 1;
    localparam int ACC_W    = 48;
    localparam int CFG_IDX_W = 3;

    // bit-serial multiplier: 32-bit multiplicand, up to 48 multiplier bits
    localparam int MUL_A_W    = 32;
    localparam int MUL_B_W    = 48;
    localparam int MUL_P_W    = MUL_A_W + MUL_B_W;
    localparam int MUL_STEP_W = 6;

    // restoring divider, one quotient bit per cycle
    localparam int DIV_N_W    = 61;
    localparam int DIV_D_W    = 32;
    localparam int DIV_CNT_W  = 6;

    // multiplier bit counts for each product
    localparam int E_STEPS  = RPM_W;
    localparam int DK_STEPS = 27;
    localparam int I_STEPS  = ACC_W;

    localparam int Y_W = 56;
    localparam int TERM_CAP_BIT = 60;
    localparam logic [DIV_N_W-1:0] TERM_CAP = DIV_N_W'(1) << TERM_CAP_BIT;
    localparam logic [DIV_D_W-1:0] MS_PER_S = DIV_D_W'(1000);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN_PROP    = 3'd0,
        CFG_GAIN_INTEG   = 3'd1,
        CFG_GAIN_DERIV   = 3'd2,
        CFG_PULSE_MIN_US = 3'd3,
        CFG_PULSE_MAX_US = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic [GAIN_W-1:0]  gain_prop;
        logic [GAIN_W-1:0]  gain_integ;
        logic [GAIN_W-1:0]  gain_deriv;
        logic [PULSE_W-1:0] pulse_min_us;
        logic [PULSE_W-1:0] pulse_max_us;
    } cfg_t;

    typedef struct packed {
        logic                  start;
        logic [MUL_STEP_W-1:0] steps;
        logic [MUL_A_W-1:0]    a;
        logic [MUL_B_W-1:0]    b;
    } mul_req_t;

    typedef struct packed {
        logic               start;
        logic [DIV_N_W-1:0] dividend;
        logic [DIV_D_W-1:0] divisor;
    } div_req_t;

endpackage

@@ rtl/pid_servo_pulse_controller.sv @@
// top level: configuration registers, pid sequencer and output register
// PID speed controller that turns setpoint and measured rpm plus a millisecond
// timestamp into a servo pulse width, with conditional integration against windup.
// One word is taken at a time; its run is shortest with integral gain zero and no
// derivative, and longest with the derivative and a rejected tentative integral,
// set by the bit-serial multiplier (one multiplier bit per cycle, up to 48) and the
// restoring divider (61 quotient bits), which run in turn. A finished word
// waits in the output register while the next input word is taken.
module pid_servo_pulse_controller #(
    parameter int GAIN_FRAC_BITS = psp_pkg::GAIN_FRAC_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [psp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [psp_pkg::GAIN_W-1:0]       cfg_data,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [psp_pkg::RPM_W-1:0]        s_setpoint_rpm,
    input  logic [psp_pkg::RPM_W-1:0]        s_measured_rpm,
    input  logic [psp_pkg::TIME_W-1:0]       s_now_ms,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [psp_pkg::PULSE_W-1:0]      m_pulse_us
);
    import psp_pkg::*;

    cfg_t                cfg_reg;
    logic                m_valid_reg;
    logic [PULSE_W-1:0]  m_pulse_us_reg;
    logic                res_valid;
    logic                res_ready;
    logic [PULSE_W-1:0]  res_pulse_us;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.gain_prop    <= '0;
            cfg_reg.gain_integ   <= '0;
            cfg_reg.gain_deriv   <= '0;
            cfg_reg.pulse_min_us <= PULSE_W'(1000);
            cfg_reg.pulse_max_us <= PULSE_W'(2000);
        end else if (cfg_valid) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_GAIN_PROP:    cfg_reg.gain_prop    <= cfg_data;
                CFG_GAIN_INTEG:   cfg_reg.gain_integ   <= cfg_data;
                CFG_GAIN_DERIV:   cfg_reg.gain_deriv   <= cfg_data;
                CFG_PULSE_MIN_US: cfg_reg.pulse_min_us <= cfg_data[PULSE_W-1:0];
                CFG_PULSE_MAX_US: cfg_reg.pulse_max_us <= cfg_data[PULSE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // output register frees the sequencer as soon as a word is handed over
    assign res_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_ready) begin
            m_valid_reg <= res_valid;
            if (res_valid) begin
                m_pulse_us_reg <= res_pulse_us;
            end
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_pulse_us = m_pulse_us_reg;

    psp_ctrl #(
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_ctrl (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg_reg),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_setpoint_rpm (s_setpoint_rpm),
        .s_measured_rpm (s_measured_rpm),
        .s_now_ms       (s_now_ms),
        .res_valid      (res_valid),
        .res_ready      (res_ready),
        .res_pulse_us   (res_pulse_us)
    );

`ifndef SYNTHESIS
    a_no_accept_while_done: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && res_valid))
        else $error("sequencer ready while a result is pending");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("sequencer ready right after taking a word");

    a_pulse_in_window: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && cfg_reg.pulse_max_us > cfg_reg.pulse_min_us) |->
        (m_pulse_us >= cfg_reg.pulse_min_us && m_pulse_us <= cfg_reg.pulse_max_us))
        else $error("pulse width outside the configured window");
`endif

endmodule

@@ rtl/psp_mul.sv @@
// bit-serial shift-add multiplier, one multiplier bit per cycle
module psp_mul (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  psp_pkg::mul_req_t              req,
    output logic                           busy,
    output logic [psp_pkg::MUL_P_W-1:0]    prod
);
    import psp_pkg::*;

    logic                  busy_reg;
    logic [MUL_STEP_W-1:0] cnt_reg;
    logic [MUL_A_W-1:0]    a_reg;
    logic [MUL_P_W-1:0]    prod_reg;
    logic [MUL_A_W:0]      sum;

    // after n steps the product sits left aligned by MUL_B_W - n bits
    assign sum = {1'b0, prod_reg[MUL_P_W-1:MUL_B_W]}
               + (prod_reg[0] ? {1'b0, a_reg} : {(MUL_A_W+1){1'b0}});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (req.start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= req.steps;
            a_reg    <= req.a;
            prod_reg <= {{MUL_A_W{1'b0}}, req.b};
        end else if (busy_reg) begin
            prod_reg <= {sum, prod_reg[MUL_B_W-1:1]};
            cnt_reg  <= cnt_reg - MUL_STEP_W'(1);
            if (cnt_reg == MUL_STEP_W'(1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    assign busy = busy_reg;
    assign prod = prod_reg;

endmodule

@@ rtl/psp_div.sv @@
// restoring divider, one quotient bit per cycle
module psp_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  psp_pkg::div_req_t             req,
    output logic                          busy,
    output logic [psp_pkg::DIV_N_W-1:0]   quo
);
    import psp_pkg::*;

    logic                 busy_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_D_W-1:0]   div_reg;
    logic [DIV_D_W-1:0]   rem_reg;
    logic [DIV_N_W-1:0]   quo_reg;
    logic [DIV_D_W:0]     trial;
    logic                 ge;
    logic [DIV_D_W:0]     diff;

    assign trial = {rem_reg, quo_reg[DIV_N_W-1]};
    assign ge    = trial >= {1'b0, div_reg};
    assign diff  = trial - {1'b0, div_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (req.start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= DIV_CNT_W'(DIV_N_W);
            div_reg  <= req.divisor;
            rem_reg  <= '0;
            quo_reg  <= req.dividend;
        end else if (busy_reg) begin
            rem_reg <= ge ? diff[DIV_D_W-1:0] : trial[DIV_D_W-1:0];
            quo_reg <= {quo_reg[DIV_N_W-2:0], ge};
            cnt_reg <= cnt_reg - DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    assign busy = busy_reg;
    assign quo  = quo_reg;

endmodule

@@ rtl/psp_ctrl.sv @@
// sequencer for the pid terms, the conditional integration and the clamp
module psp_ctrl #(
    parameter int GAIN_FRAC_BITS = psp_pkg::GAIN_FRAC_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  psp_pkg::cfg_t                 cfg,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [psp_pkg::RPM_W-1:0]     s_setpoint_rpm,
    input  logic [psp_pkg::RPM_W-1:0]     s_measured_rpm,
    input  logic [psp_pkg::TIME_W-1:0]    s_now_ms,
    output logic                          res_valid,
    input  logic                          res_ready,
    output logic [psp_pkg::PULSE_W-1:0]   res_pulse_us
);
    import psp_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE, ST_MUL_P, ST_MUL_D, ST_DIV_D, ST_MUL_E, ST_MUL_I, ST_DIV_I, ST_DONE
    } state_t;

    function automatic logic signed [Y_W-1:0] signed_term(input logic [DIV_N_W-1:0] mag,
                                                         input logic neg);
        logic signed [Y_W-1:0] v;
        v = $signed(Y_W'(mag));
        return neg ? -v : v;
    endfunction

    state_t                   state_reg;
    logic signed [ACC_W-1:0]  integral_acc_reg;
    logic signed [ERR_W-1:0]  prev_error_reg;
    logic [TIME_W-1:0]        last_time_reg;
    logic                     first_call_reg;

    logic signed [ERR_W-1:0]  e_reg;
    logic [TIME_W-1:0]        dt_reg;
    logic                     d_en_reg;
    logic                     de_neg_reg;
    logic [DK_STEPS-1:0]      de_k_reg;
    logic signed [Y_W-1:0]    p_reg;
    logic signed [Y_W-1:0]    d_reg;
    logic signed [Y_W-1:0]    it_reg;
    logic signed [ACC_W-1:0]  tent_reg;
    logic                     i_neg_reg;
    logic                     final_reg;

    mul_req_t                 mul_req;
    div_req_t                 div_req;
    logic                     mul_busy;
    logic                     div_busy;
    logic [MUL_P_W-1:0]       mul_prod;
    logic [DIV_N_W-1:0]       div_quo;

    logic signed [ERR_W-1:0]  e_in;
    logic [RPM_W-1:0]         e_in_mag;
    logic [RPM_W-1:0]         e_mag;
    logic [TIME_W-1:0]        dt_in;
    logic signed [ERR_W:0]    de_in;
    logic [ERR_W-1:0]         de_mag;
    logic [DK_STEPS-1:0]      de_k;

    logic [ACC_W-1:0]         p_hi;
    logic [ACC_W-1:0]         p_mag;
    logic [MUL_P_W-1:0]       i_shift;
    logic [DIV_N_W-1:0]       i_mag;
    logic [DIV_N_W-1:0]       d_mag;
    logic signed [ACC_W+1:0]  ed_s;
    logic signed [ACC_W+1:0]  tent_sum;
    logic signed [ACC_W-1:0]  tent_sat;
    logic [ACC_W-1:0]         tent_mag;
    logic [ACC_W-1:0]         acc_mag;
    logic signed [Y_W-1:0]    i_val;
    logic signed [Y_W-1:0]    y_tent;
    logic signed [Y_W-1:0]    y_fin;
    logic [PULSE_W-1:0]       range_u;
    logic signed [Y_W-1:0]    range_s;
    logic                     e_pos;
    logic                     push_hi;
    logic                     push_lo;
    logic                     redo_i;
    logic [PULSE_W-1:0]       y_clamp;

    assign e_in     = $signed({1'b0, s_setpoint_rpm}) - $signed({1'b0, s_measured_rpm});
    assign e_in_mag = e_in[ERR_W-1] ? RPM_W'(-e_in) : e_in[RPM_W-1:0];
    assign e_mag    = e_reg[ERR_W-1] ? RPM_W'(-e_reg) : e_reg[RPM_W-1:0];
    assign dt_in    = s_now_ms - last_time_reg;
    assign de_in    = $signed({e_in[ERR_W-1], e_in})
                    - $signed({prev_error_reg[ERR_W-1], prev_error_reg});
    assign de_mag   = de_in[ERR_W] ? ERR_W'(-de_in) : de_in[ERR_W-1:0];
    assign de_k     = DK_STEPS'(de_mag) * DK_STEPS'(1000);

    // short products are left aligned in the multiplier register
    assign p_hi    = mul_prod[MUL_P_W-1:MUL_P_W-ACC_W];
    assign p_mag   = p_hi >> GAIN_FRAC_BITS;
    assign i_shift = mul_prod >> GAIN_FRAC_BITS;
    assign i_mag   = (|i_shift[MUL_P_W-1:TERM_CAP_BIT]) ? TERM_CAP
                                                         : i_shift[DIV_N_W-1:0];
    assign d_mag   = div_quo >> GAIN_FRAC_BITS;

    // tentative integral, saturated to the accumulator width
    assign ed_s     = $signed({2'b00, p_hi});
    assign tent_sum = $signed({{2{integral_acc_reg[ACC_W-1]}}, integral_acc_reg})
                    + (e_reg[ERR_W-1] ? -ed_s : ed_s);
    always_comb begin
        if (tent_sum[ACC_W+1:ACC_W-1] == 3'b000 || tent_sum[ACC_W+1:ACC_W-1] == 3'b111) begin
            tent_sat = tent_sum[ACC_W-1:0];
        end else if (tent_sum[ACC_W+1]) begin
            tent_sat = {1'b1, {(ACC_W-1){1'b0}}};
        end else begin
            tent_sat = {1'b0, {(ACC_W-1){1'b1}}};
        end
    end
    assign tent_mag = tent_sat[ACC_W-1] ? ACC_W'(-tent_sat) : tent_sat;
    assign acc_mag  = integral_acc_reg[ACC_W-1] ? ACC_W'(-integral_acc_reg)
                                                : integral_acc_reg;

    assign i_val   = signed_term(div_quo, i_neg_reg);
    assign y_tent  = p_reg + i_val + d_reg;
    assign y_fin   = p_reg + it_reg + d_reg;
    assign range_u = (cfg.pulse_max_us > cfg.pulse_min_us)
                   ? cfg.pulse_max_us - cfg.pulse_min_us : '0;
    assign range_s = $signed({{(Y_W-PULSE_W){1'b0}}, range_u});
    assign e_pos   = !e_reg[ERR_W-1] && (e_reg != '0);
    assign push_hi = (y_tent > range_s) && e_pos;
    assign push_lo = y_tent[Y_W-1] && e_reg[ERR_W-1];
    assign redo_i  = !final_reg && (push_hi || push_lo);

    always_comb begin
        if (y_fin > range_s) begin
            y_clamp = range_u;
        end else if (y_fin[Y_W-1]) begin
            y_clamp = '0;
        end else begin
            y_clamp = y_fin[PULSE_W-1:0];
        end
    end

    assign res_pulse_us = cfg.pulse_min_us + y_clamp;
    assign res_valid    = (state_reg == ST_DONE);
    assign s_ready      = (state_reg == ST_IDLE);

    always_comb begin
        mul_req = '0;
        div_req = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    mul_req = '{1'b1, MUL_STEP_W'(E_STEPS), cfg.gain_prop,
                                MUL_B_W'(e_in_mag)};
                end
            end
            ST_MUL_P: begin
                if (!mul_busy) begin
                    if (d_en_reg) begin
                        mul_req = '{1'b1, MUL_STEP_W'(DK_STEPS), cfg.gain_deriv,
                                    MUL_B_W'(de_k_reg)};
                    end else begin
                        mul_req = '{1'b1, MUL_STEP_W'(E_STEPS), dt_reg, MUL_B_W'(e_mag)};
                    end
                end
            end
            ST_MUL_D: begin
                if (!mul_busy) begin
                    div_req = '{1'b1,
                        DIV_N_W'(mul_prod[MUL_P_W-1:MUL_B_W-DK_STEPS]), dt_reg};
                end
            end
            ST_DIV_D: begin
                if (!div_busy) begin
                    mul_req = '{1'b1, MUL_STEP_W'(E_STEPS), dt_reg, MUL_B_W'(e_mag)};
                end
            end
            ST_MUL_E: begin
                if (!mul_busy && cfg.gain_integ != '0) begin
                    mul_req = '{1'b1, MUL_STEP_W'(I_STEPS), cfg.gain_integ, tent_mag};
                end
            end
            ST_MUL_I: begin
                if (!mul_busy) begin
                    div_req = '{1'b1, i_mag, MS_PER_S};
                end
            end
            ST_DIV_I: begin
                if (!div_busy && redo_i) begin
                    mul_req = '{1'b1, MUL_STEP_W'(I_STEPS), cfg.gain_integ, acc_mag};
                end
            end
            ST_DONE: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            integral_acc_reg <= '0;
            prev_error_reg   <= '0;
            last_time_reg    <= '0;
            first_call_reg   <= 1'b1;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        e_reg          <= e_in;
                        dt_reg         <= dt_in;
                        de_neg_reg     <= de_in[ERR_W];
                        de_k_reg       <= de_k;
                        d_en_reg       <= !first_call_reg && (dt_in != '0);
                        last_time_reg  <= s_now_ms;
                        prev_error_reg <= e_in;
                        first_call_reg <= 1'b0;
                        state_reg      <= ST_MUL_P;
                    end
                end
                ST_MUL_P: begin
                    if (!mul_busy) begin
                        p_reg <= signed_term(DIV_N_W'(p_mag), e_reg[ERR_W-1]);
                        if (d_en_reg) begin
                            state_reg <= ST_MUL_D;
                        end else begin
                            d_reg     <= '0;
                            state_reg <= ST_MUL_E;
                        end
                    end
                end
                ST_MUL_D: begin
                    if (!mul_busy) begin
                        state_reg <= ST_DIV_D;
                    end
                end
                ST_DIV_D: begin
                    if (!div_busy) begin
                        d_reg     <= signed_term(d_mag, de_neg_reg);
                        state_reg <= ST_MUL_E;
                    end
                end
                ST_MUL_E: begin
                    if (!mul_busy) begin
                        tent_reg <= tent_sat;
                        if (cfg.gain_integ != '0) begin
                            i_neg_reg <= tent_sat[ACC_W-1];
                            final_reg <= 1'b0;
                            state_reg <= ST_MUL_I;
                        end else begin
                            integral_acc_reg <= '0;
                            it_reg           <= '0;
                            state_reg        <= ST_DONE;
                        end
                    end
                end
                ST_MUL_I: begin
                    if (!mul_busy) begin
                        state_reg <= ST_DIV_I;
                    end
                end
                ST_DIV_I: begin
                    if (!div_busy) begin
                        if (redo_i) begin
                            // tentative value would wind up further, rerun on the old integral
                            i_neg_reg <= integral_acc_reg[ACC_W-1];
                            final_reg <= 1'b1;
                            state_reg <= ST_MUL_I;
                        end else begin
                            it_reg <= i_val;
                            if (!final_reg) begin
                                integral_acc_reg <= tent_reg;
                            end
                            state_reg <= ST_DONE;
                        end
                    end
                end
                ST_DONE: begin
                    if (res_ready) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    psp_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mul_req),
        .busy    (mul_busy),
        .prod    (mul_prod)
    );

    psp_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .busy    (div_busy),
        .quo     (div_quo)
    );

endmodule
